### hw/rtl/erp_pkg.sv
package erp_pkg;

   // Fixed widths of the transaction fields
   localparam int COORD_WIDTH = 32;
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   // Offsets from the pivot grow a little under rotation; two spare bits cover it.
   localparam int ROT_WIDTH = COORD_WIDTH + 3;
   localparam int ANGLE_WIDTH = 17;
   localparam int CSR_INDEX_WIDTH = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ANGLE_X = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ANGLE_Y = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ANGLE_Z = 2'd2;

   localparam int TRIG_FRAC_BITS_DEFAULT = 15;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Angle units are 1/128 degree
   localparam int HALF_TURN_DEG = 180;
   localparam int UNITS_PER_DEGREE = 128;
   localparam int HALF_TURN = HALF_TURN_DEG * UNITS_PER_DEGREE;
   localparam int FULL_TURN = 2 * HALF_TURN;
   localparam int QUARTER_TURN = HALF_TURN / 2;
   localparam int EIGHTH_TURN = HALF_TURN / 4;

   // pi / 23040 in unsigned Q40
   localparam logic [30:0] RAD_PER_UNIT_Q40 = 31'd149922641;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam int SERIES_TERMS = 5;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
      logic set_start;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] rotated_x;
      logic signed [COORD_WIDTH-1:0] rotated_y;
      logic signed [COORD_WIDTH-1:0] rotated_z;
   } rsp_type;

   // One queued point: its offset from the pivot and the pivot itself
   typedef struct packed {
      logic signed [DIFF_WIDTH-1:0] diff_x;
      logic signed [DIFF_WIDTH-1:0] diff_y;
      logic signed [DIFF_WIDTH-1:0] diff_z;
      logic signed [COORD_WIDTH-1:0] pivot_x;
      logic signed [COORD_WIDTH-1:0] pivot_y;
      logic signed [COORD_WIDTH-1:0] pivot_z;
   } entry_type;

   // Reciprocals of the Horner series divisors, innermost term first. The sine
   // divisors are 110, 72, 42, 20 and 6, the cosine ones 90, 56, 30, 12 and 2.
   // A dividend below 2^31 times the reciprocal, shifted right by the matching
   // series_shift, gives the exact floor quotient.
   function automatic logic [31:0] series_recip(input logic want_sin, input logic [2:0] idx);
      logic [31:0] m;
      m = 32'd0;
      case (idx)
         3'd0: m = want_sin ? 32'd2498890064 : 32'd3054198967;
         3'd1: m = want_sin ? 32'd3817748708 : 32'd2454267027;
         3'd2: m = want_sin ? 32'd3272356036 : 32'd2290649225;
         3'd3: m = want_sin ? 32'd3435973837 : 32'd2863311531;
         3'd4: m = want_sin ? 32'd2863311531 : 32'd2147483648;
         default: m = 32'd0;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] series_shift(input logic want_sin, input logic [2:0] idx);
      logic [5:0] k;
      k = 6'd0;
      case (idx)
         3'd0: k = 6'd38;
         3'd1: k = want_sin ? 6'd38 : 6'd37;
         3'd2: k = want_sin ? 6'd37 : 6'd36;
         3'd3: k = want_sin ? 6'd36 : 6'd35;
         3'd4: k = want_sin ? 6'd34 : 6'd32;
         default: k = 6'd0;
      endcase
      return k;
   endfunction

endpackage

### hw/rtl/erp_trig.sv
module erp_trig
   import erp_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ANGLE_WIDTH-1:0] csr_write_data,
   output logic signed [2:0][TRIG_FRAC_BITS:0] sin_values,
   output logic signed [2:0][TRIG_FRAC_BITS:0] cos_values,
   output logic [2:0] axis_on,
   output logic busy
);

   localparam int TW = TRIG_FRAC_BITS + 1;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_WRAP = 4'd1;
   localparam logic [3:0] ST_FOLD = 4'd2;
   localparam logic [3:0] ST_RAD = 4'd3;
   localparam logic [3:0] ST_SQ = 4'd4;
   localparam logic [3:0] ST_TERM = 4'd5;
   localparam logic [3:0] ST_DIV = 4'd6;
   localparam logic [3:0] ST_SINMUL = 4'd7;
   localparam logic [3:0] ST_WRITE = 4'd8;

   logic [3:0] state_ff, state_in;
   logic signed [ANGLE_WIDTH-1:0] angle_ff [3];
   logic [2:0] pending_ff, pending_in;
   logic [1:0] axis_ff;
   logic signed [ANGLE_WIDTH-1:0] ang_ff;
   logic [15:0] wrap_ff;
   logic [1:0] quad_ff;
   logic swap_ff;
   logic [12:0] fold_ff;
   logic [29:0] rad_ff;
   logic [29:0] sq_ff;
   logic [30:0] t_ff;
   logic [30:0] s0_ff;
   logic want_sin_ff;
   logic [2:0] term_ff;
   logic [30:0] dividend_ff;
   logic signed [TW-1:0] sin_ff [3];
   logic signed [TW-1:0] cos_ff [3];

   logic [30:0] mul_a;
   logic [31:0] mul_b;
   logic [62:0] mul_p, rad_sum;
   logic [1:0] pick;
   logic [31:0] recip;
   logic [5:0] div_shift;
   logic [62:0] quot_wide;
   logic [30:0] quotient;
   logic signed [18:0] ang_wide, wrap_val;
   logic [15:0] rem_q;
   logic [13:0] rem_val;
   logic [1:0] quad_val;
   logic [30:0] sm, cm;
   logic signed [TW-1:0] sin_new, cos_new;

   function automatic logic signed [TW-1:0] to_trig(input logic [30:0] q, input logic neg);
      logic [31:0] s;
      logic [TW-1:0] r;
      s = {1'b0, q} + (32'd1 << (29 - TRIG_FRAC_BITS));
      r = s[30:30-TRIG_FRAC_BITS];
      if (!neg && r[TW-1]) begin
         return signed'({1'b0, {(TW-1){1'b1}}});
      end
      return neg ? signed'(-r) : signed'(r);
   endfunction

   // Lowest pending axis goes first
   always_comb begin
      pick = 2'd0;
      if (pending_ff[0]) begin
         pick = 2'd0;
      end else if (pending_ff[1]) begin
         pick = 2'd1;
      end else begin
         pick = 2'd2;
      end
   end

   always_comb begin
      pending_in = pending_ff;
      if (state_ff == ST_IDLE && pending_ff != 3'b000) begin
         pending_in[pick] = 1'b0;
      end
      if (csr_write_enable && csr_index <= REG_ANGLE_Z) begin
         pending_in[csr_index] = 1'b1;
      end
   end

   // Shared multiplier of the series
   always_comb begin
      mul_a = 31'd0;
      mul_b = 32'd0;
      case (state_ff)
         ST_RAD: begin
            mul_a = {18'd0, fold_ff};
            mul_b = {1'b0, RAD_PER_UNIT_Q40};
         end
         ST_SQ: begin
            mul_a = {1'b0, rad_ff};
            mul_b = {2'b0, rad_ff};
         end
         ST_TERM: begin
            mul_a = {1'b0, sq_ff};
            mul_b = {1'b0, t_ff};
         end
         ST_DIV: begin
            mul_a = dividend_ff;
            mul_b = recip;
         end
         ST_SINMUL: begin
            mul_a = {1'b0, rad_ff};
            mul_b = {1'b0, t_ff};
         end
         default: begin
            mul_a = 31'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign mul_p = 63'(mul_a) * 63'(mul_b);
   assign rad_sum = mul_p + 63'd512;

   // Division by the small series constants: multiply by the reciprocal on the
   // shared multiplier and keep the bits above the matching shift.
   assign recip = series_recip(want_sin_ff, term_ff);
   assign div_shift = series_shift(want_sin_ff, term_ff);
   assign quot_wide = mul_p >> div_shift;
   assign quotient = quot_wide[30:0];

   // Reduction of the angle to one full turn and folding to 45 degrees
   assign ang_wide = 19'(ang_ff);
   always_comb begin
      wrap_val = ang_wide;
      if (ang_wide < 0) begin
         wrap_val = ang_wide + 19'(FULL_TURN);
         if (wrap_val < 0) begin
            wrap_val = ang_wide + 19'(2 * FULL_TURN);
         end
      end else if (ang_wide >= 19'(FULL_TURN)) begin
         wrap_val = ang_wide - 19'(FULL_TURN);
      end
   end

   always_comb begin
      if (wrap_ff >= 16'(3 * QUARTER_TURN)) begin
         quad_val = 2'd3;
         rem_q = wrap_ff - 16'(3 * QUARTER_TURN);
      end else if (wrap_ff >= 16'(2 * QUARTER_TURN)) begin
         quad_val = 2'd2;
         rem_q = wrap_ff - 16'(2 * QUARTER_TURN);
      end else if (wrap_ff >= 16'(QUARTER_TURN)) begin
         quad_val = 2'd1;
         rem_q = wrap_ff - 16'(QUARTER_TURN);
      end else begin
         quad_val = 2'd0;
         rem_q = wrap_ff;
      end
      rem_val = rem_q[13:0];
   end

   // Quadrant mapping of the folded sine and cosine
   always_comb begin
      sm = swap_ff ? t_ff : s0_ff;
      cm = swap_ff ? s0_ff : t_ff;
      case (quad_ff)
         2'd0: begin
            sin_new = to_trig(sm, 1'b0);
            cos_new = to_trig(cm, 1'b0);
         end
         2'd1: begin
            sin_new = to_trig(cm, 1'b0);
            cos_new = to_trig(sm, 1'b1);
         end
         2'd2: begin
            sin_new = to_trig(sm, 1'b1);
            cos_new = to_trig(cm, 1'b1);
         end
         default: begin
            sin_new = to_trig(cm, 1'b1);
            cos_new = to_trig(sm, 1'b0);
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   state_in = (pending_ff != 3'b000) ? ST_WRAP : ST_IDLE;
         ST_WRAP:   state_in = ST_FOLD;
         ST_FOLD:   state_in = ST_RAD;
         ST_RAD:    state_in = ST_SQ;
         ST_SQ:     state_in = ST_TERM;
         ST_TERM:   state_in = ST_DIV;
         ST_DIV: begin
            if (term_ff == 3'(SERIES_TERMS - 1)) begin
               state_in = want_sin_ff ? ST_SINMUL : ST_WRITE;
            end else begin
               state_in = ST_TERM;
            end
         end
         ST_SINMUL: state_in = ST_TERM;
         ST_WRITE:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pending_ff <= 3'b000;
         for (int i = 0; i < 3; i++) begin
            angle_ff[i] <= '0;
            sin_ff[i] <= '0;
            cos_ff[i] <= signed'({1'b0, {(TW-1){1'b1}}});
         end
      end else begin
         state_ff <= state_in;
         pending_ff <= pending_in;
         if (csr_write_enable && csr_index <= REG_ANGLE_Z) begin
            angle_ff[csr_index] <= signed'(csr_write_data);
         end
         if (state_ff == ST_WRITE) begin
            sin_ff[axis_ff] <= sin_new;
            cos_ff[axis_ff] <= cos_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            axis_ff <= pick;
            ang_ff <= angle_ff[pick];
            want_sin_ff <= 1'b1;
            term_ff <= 3'd0;
            t_ff <= Q30_ONE;
         end
         ST_WRAP: wrap_ff <= wrap_val[15:0];
         ST_FOLD: begin
            quad_ff <= quad_val;
            swap_ff <= rem_val > 14'(EIGHTH_TURN);
            fold_ff <= (rem_val > 14'(EIGHTH_TURN)) ?
                       13'(14'(QUARTER_TURN) - rem_val) : rem_val[12:0];
         end
         ST_RAD: rad_ff <= rad_sum[39:10];
         ST_SQ: sq_ff <= mul_p[59:30];
         ST_TERM: dividend_ff <= mul_p[60:30];
         ST_DIV: begin
            t_ff <= Q30_ONE - quotient;
            term_ff <= term_ff + 3'd1;
         end
         ST_SINMUL: begin
            s0_ff <= mul_p[60:30];
            t_ff <= Q30_ONE;
            term_ff <= 3'd0;
            want_sin_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sin_values[i] = sin_ff[i];
         cos_values[i] = cos_ff[i];
         axis_on[i] = angle_ff[i] != '0;
      end
   end

   assign busy = (pending_ff != 3'b000) || (state_ff != ST_IDLE);

endmodule

### hw/rtl/erp_front.sv
module erp_front
   import erp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_data,
   input  logic hold,
   input  logic queue_full,
   output logic push,
   output entry_type push_data
);

   logic signed [COORD_WIDTH-1:0] pivot_ff [3];
   logic signed [COORD_WIDTH-1:0] point [3];
   logic signed [COORD_WIDTH-1:0] pivot_now [3];
   logic signed [DIFF_WIDTH-1:0] diff [3];

   assign req_stall = queue_full || hold;
   assign push = req_valid && !req_stall;

   assign point[0] = req_data.point_x;
   assign point[1] = req_data.point_y;
   assign point[2] = req_data.point_z;

   // A set start point is its own pivot, so its offset is zero.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pivot_now[i] = req_data.set_start ? point[i] : pivot_ff[i];
         diff[i] = DIFF_WIDTH'(point[i]) - DIFF_WIDTH'(pivot_now[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pivot_ff[i] <= '0;
         end
      end else if (push && req_data.set_start) begin
         for (int i = 0; i < 3; i++) begin
            pivot_ff[i] <= point[i];
         end
      end
   end

   assign push_data.diff_x = diff[0];
   assign push_data.diff_y = diff[1];
   assign push_data.diff_z = diff[2];
   assign push_data.pivot_x = pivot_now[0];
   assign push_data.pivot_y = pivot_now[1];
   assign push_data.pivot_z = pivot_now[2];

endmodule

### hw/rtl/erp_queue.sv
module erp_queue
   import erp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  entry_type push_data,
   input  logic pop,
   output entry_type pop_data,
   output logic full,
   output logic empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");

endmodule

### hw/rtl/erp_back.sv
module erp_back
   import erp_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic queue_empty,
   input  entry_type pop_data,
   output logic pop,
   input  logic signed [2:0][TRIG_FRAC_BITS:0] sin_values,
   input  logic signed [2:0][TRIG_FRAC_BITS:0] cos_values,
   input  logic [2:0] axis_on,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_data
);

   localparam int TW = TRIG_FRAC_BITS + 1;
   localparam int CW = TW + 1;
   localparam int DW = ROT_WIDTH;
   localparam int PW = DW + CW;
   localparam int SW = PW + 1;

   localparam logic [1:0] BK_IDLE = 2'd0;
   localparam logic [1:0] BK_AXIS = 2'd1;
   localparam logic [1:0] BK_SUM = 2'd2;

   localparam logic signed [DW-1:0] SAT_HI = {{(DW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [DW-1:0] SAT_LO = {{(DW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   logic [1:0] state_ff, state_in;
   logic [1:0] axis_ff;
   logic [2:0] step_ff;
   logic signed [DW-1:0] d_ff [3];
   logic signed [COORD_WIDTH-1:0] pivot_ff [3];
   logic signed [PW-1:0] prod_ff, acc_ff;
   logic signed [DW-1:0] n0_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic signed [CW-1:0] s_coef, c_coef, coef;
   logic signed [DW-1:0] op_a, op_b, op;
   logic signed [PW-1:0] product;
   logic signed [DW-1:0] rounded;
   logic signed [DW-1:0] total [3];
   logic signed [COORD_WIDTH-1:0] sat [3];
   logic slot_free, last_axis, skip_axis;

   // Sum of the two products rounded half up to whole coordinate LSBs
   function automatic logic signed [DW-1:0] round_sum(input logic signed [PW-1:0] x,
                                                       input logic signed [PW-1:0] y);
      logic signed [SW-1:0] s;
      s = SW'(x) + SW'(y) + (SW'(1) <<< (TRIG_FRAC_BITS - 1));
      s = s >>> TRIG_FRAC_BITS;
      return s[DW-1:0];
   endfunction

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_axis = axis_ff == 2'd2;
   assign skip_axis = !axis_on[axis_ff];
   assign pop = (state_ff == BK_IDLE) && !queue_empty;

   // An element of a packed array is unsigned, so the sign is restored first.
   assign s_coef = CW'(signed'(sin_values[axis_ff]));
   assign c_coef = CW'(signed'(cos_values[axis_ff]));
   assign op_a = (axis_ff == 2'd0) ? d_ff[1] : d_ff[0];
   assign op_b = (axis_ff == 2'd2) ? d_ff[1] : d_ff[2];

   // Rotation about y has the sine terms of the opposite sign.
   always_comb begin
      case (step_ff)
         3'd0: begin
            coef = c_coef;
            op = op_a;
         end
         3'd1: begin
            coef = (axis_ff == 2'd1) ? s_coef : -s_coef;
            op = op_b;
         end
         3'd2: begin
            coef = (axis_ff == 2'd1) ? -s_coef : s_coef;
            op = op_a;
         end
         default: begin
            coef = c_coef;
            op = op_b;
         end
      endcase
   end

   assign product = PW'(coef) * PW'(op);
   assign rounded = round_sum(acc_ff, prod_ff);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         total[i] = DW'(pivot_ff[i]) + d_ff[i];
         if (total[i] > SAT_HI) begin
            sat[i] = SAT_HI[COORD_WIDTH-1:0];
         end else if (total[i] < SAT_LO) begin
            sat[i] = SAT_LO[COORD_WIDTH-1:0];
         end else begin
            sat[i] = total[i][COORD_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: state_in = queue_empty ? BK_IDLE : BK_AXIS;
         BK_AXIS: begin
            if ((skip_axis && step_ff == 3'd0) || step_ff == 3'd4) begin
               state_in = last_axis ? BK_SUM : BK_AXIS;
            end
         end
         BK_SUM: state_in = slot_free ? BK_IDLE : BK_SUM;
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_SUM && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            axis_ff <= 2'd0;
            step_ff <= 3'd0;
            d_ff[0] <= DW'(pop_data.diff_x);
            d_ff[1] <= DW'(pop_data.diff_y);
            d_ff[2] <= DW'(pop_data.diff_z);
            pivot_ff[0] <= pop_data.pivot_x;
            pivot_ff[1] <= pop_data.pivot_y;
            pivot_ff[2] <= pop_data.pivot_z;
         end
         BK_AXIS: begin
            if (skip_axis && step_ff == 3'd0) begin
               axis_ff <= axis_ff + 2'd1;
            end else begin
               prod_ff <= product;
               step_ff <= (step_ff == 3'd4) ? 3'd0 : step_ff + 3'd1;
               case (step_ff)
                  3'd1, 3'd3: acc_ff <= prod_ff;
                  3'd2: n0_ff <= rounded;
                  3'd4: begin
                     axis_ff <= axis_ff + 2'd1;
                     case (axis_ff)
                        2'd0: begin
                           d_ff[1] <= n0_ff;
                           d_ff[2] <= rounded;
                        end
                        2'd1: begin
                           d_ff[0] <= n0_ff;
                           d_ff[2] <= rounded;
                        end
                        default: begin
                           d_ff[0] <= n0_ff;
                           d_ff[1] <= rounded;
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_SUM: begin
            if (slot_free) begin
               rsp_ff.rotated_x <= sat[0];
               rsp_ff.rotated_y <= sat[1];
               rsp_ff.rotated_z <= sat[2];
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == BK_AXIS)
      else $error("point taken from the queue without starting its rotation");

endmodule

### hw/rtl/euler_rotate_about_pivot.sv
// Rotates a stream of signed Q16.16 points about the first point of each set:
// a transaction with set_start high stores its point as the pivot, and every
// point p (the pivot included) gives pivot + Rz(Ry(Rx(p - pivot))), rounded
// half up to whole LSBs and saturated to the 32-bit coordinate range. The
// three angles are written through the csr port in 1/128 degree; an axis
// whose angle is zero is passed through untouched. A front stage places each
// accepted transaction's pivot offset in a queue of QUEUE_DEPTH entries (two
// by default); the back end rotates it on one shared multiplier, taking it
// from the queue, running the multiply steps of each active axis, skipping
// each bypassed axis and then summing and saturating, and the result waits
// in an output register while the next item is already being taken in.
// After each angle write the sine and cosine are derived by a series unit
// whose constant divisions are reciprocal multiplications on its own shared
// multiplier; during the derivation req_stall stays high.
module euler_rotate_about_pivot
   import erp_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ANGLE_WIDTH-1:0] csr_write_data
);

   logic signed [2:0][TRIG_FRAC_BITS:0] sin_values;
   logic signed [2:0][TRIG_FRAC_BITS:0] cos_values;
   logic [2:0] axis_on;
   logic trig_busy;
   logic hold;
   logic push, pop, queue_full, queue_empty;
   entry_type push_data, pop_data;

   // New transactions wait while an angle is being written or turned into sine and cosine.
   assign hold = trig_busy || csr_write_enable;

   erp_trig #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_trig (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .sin_values(sin_values),
      .cos_values(cos_values),
      .axis_on(axis_on),
      .busy(trig_busy)
   );

   erp_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .hold(hold),
      .queue_full(queue_full),
      .push(push),
      .push_data(push_data)
   );

   erp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .pop(pop),
      .pop_data(pop_data),
      .full(queue_full),
      .empty(queue_empty)
   );

   erp_back #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(queue_empty),
      .pop_data(pop_data),
      .pop(pop),
      .sin_values(sin_values),
      .cos_values(cos_values),
      .axis_on(axis_on),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   // A transaction is never taken while the angle tables are stale.
   a_accept_with_fresh_trig: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !trig_busy)
      else $error("transaction accepted during sine and cosine derivation");

   // Every valid angle write starts a derivation.
   a_write_starts_trig: assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && csr_index <= REG_ANGLE_Z) |=> trig_busy)
      else $error("angle write did not start a derivation");

endmodule
